// ===== sv/rme_pkg.sv =====
// Package for the register machine executor.
// Holds shared widths, opcodes, status codes, transaction and pipeline types.
// No dependencies.
package rme_pkg;

   localparam int INDEX_BITS   = 18;
   localparam int NEXT_INDEX_W = 18;
   localparam int WORD_W       = 64;
   localparam int HALF_W       = 32;
   localparam int REG_ADDR_W   = 8;
   localparam int REG_COUNT    = 256;
   localparam int COUNT_W      = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_LIMIT   = 3'h0;
   localparam logic [COUNT_W-1:0]    STEP_LIMIT_RESET = 32'd10000;

   localparam logic [7:0] OP_TRAP = 8'h00;
   localparam logic [7:0] OP_MULR = 8'h18;
   localparam logic [7:0] OP_MULI = 8'h19;
   localparam logic [7:0] OP_ADDR = 8'h20;
   localparam logic [7:0] OP_ADDI = 8'h21;
   localparam logic [7:0] OP_SUBR = 8'h24;
   localparam logic [7:0] OP_SUBI = 8'h25;
   localparam logic [7:0] OP_BZF  = 8'h42;
   localparam logic [7:0] OP_BZB  = 8'h43;
   localparam logic [7:0] OP_BPF  = 8'h44;
   localparam logic [7:0] OP_BPB  = 8'h45;
   localparam logic [7:0] OP_SETL = 8'hE3;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_TRAP  = 2'd1;
   localparam logic [1:0] ST_LIMIT = 2'd2;
   localparam logic [1:0] ST_BADOP = 2'd3;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] x_field;
      logic [7:0] y_field;
      logic [7:0] z_field;
   } req_type;

   typedef struct packed {
      logic [NEXT_INDEX_W-1:0] next_index;
      logic [1:0]              status;
      logic                    wrote;
      logic [7:0]              dest_reg;
      logic [WORD_W-1:0]       dest_value;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [REG_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]     data;
   } wb_type;

   typedef struct packed {
      logic                  wrote;
      logic                  busy;
      logic [REG_ADDR_W-1:0] dest;
      logic [WORD_W-1:0]     value;
   } fwd_type;

   typedef struct packed {
      logic [NEXT_INDEX_W-1:0] next_index;
      logic [1:0]              status;
      logic                    wrote;
      logic [REG_ADDR_W-1:0]   dest_reg;
      logic [WORD_W-1:0]       value;
      logic                    is_mul;
      logic [WORD_W-1:0]       p_ll;
      logic [HALF_W-1:0]       p_lh;
      logic [HALF_W-1:0]       p_hl;
   } exec_res_type;

   function automatic logic is_branch(input logic [7:0] op);
      return (op == OP_BZF) || (op == OP_BZB) || (op == OP_BPF) || (op == OP_BPB);
   endfunction

   function automatic logic uses_port_a(input logic [7:0] op);
      return is_branch(op) || (op == OP_MULR) || (op == OP_MULI) || (op == OP_ADDR)
         || (op == OP_ADDI) || (op == OP_SUBR) || (op == OP_SUBI);
   endfunction

   function automatic logic uses_port_b(input logic [7:0] op);
      return (op == OP_MULR) || (op == OP_ADDR) || (op == OP_SUBR);
   endfunction

endpackage

// ===== sv/register_machine_executor_unit.sv =====
// Top level of the register machine executor.
// Instantiates rme_exec, rme_result and rme_regfile and holds the step limit register.
// Depends on rme_pkg.
//
// Each req transaction carries one fetched instruction (opcode, X, Y, Z); each
// instruction yields exactly one rsp transaction with the next fetch index, the
// halt status and the register write it made, in instruction order.
// An accepted instruction enters the execute register at that edge and moves on to
// the result register once it can proceed. One instruction is accepted per cycle
// while nothing stalls. An instruction that reads a register written by the MUL
// just ahead of it waits until the final 64-bit sum of the multiply partial
// products is formed in the result stage. When rsp_ready is low the result
// register holds, the execute register fills, and req_ready drops only once both
// are full. Reset empties the pipeline, zeroes the instruction index, step count
// and status, sets the step limit to 10000, and makes every register read as zero
// at once through per-register valid bits; no clearing pass is needed. The step
// limit sits at CSR byte address 0 and is to be written only while idle; the user
// must ensure this, as the block itself does not enforce it.
module register_machine_executor_unit
   import rme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0]    step_limit_ff, step_limit_in;
   logic                  csr_hit;
   logic                  exec_go;
   logic                  res_ready;
   logic                  rd_en;
   logic [REG_ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [WORD_W-1:0]     rd_data_a, rd_data_b;
   exec_res_type          res;
   wb_type                wb;
   fwd_type               fwd;

   assign csr_pready    = 1'b1;
   assign csr_hit       = (csr_paddr[CSR_ADDR_W-1:2] == CSR_STEP_LIMIT[CSR_ADDR_W-1:2]);
   assign step_limit_in = (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit)
                          ? COUNT_W'(csr_pwdata) : step_limit_ff;
   assign csr_prdata    = csr_hit ? CSR_DATA_W'(step_limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= STEP_LIMIT_RESET;
      end else begin
         step_limit_ff <= step_limit_in;
      end
   end

   rme_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .step_limit (step_limit_ff),
      .fwd        (fwd),
      .res_ready  (res_ready),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .rd_en      (rd_en),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .go         (exec_go),
      .res        (res)
   );

   rme_result u_result (
      .clock     (clock),
      .reset     (reset),
      .go        (exec_go),
      .res       (res),
      .res_ready (res_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wb        (wb),
      .fwd       (fwd)
   );

   rme_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wb        (wb),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

`ifndef ASSERT_OFF
   a_wb_after_exec: assert property (@(posedge clock) disable iff (reset)
      wb.en |-> $past(exec_go))
      else $error("Register write without a result loaded in the previous cycle.");

   a_exec_fills_result: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid)
      else $error("Executed instruction did not reach the result register.");

   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_RUN)) |-> !rsp_data.wrote)
      else $error("Halted result reports a register write.");
`endif

endmodule

// ===== sv/rme_regfile.sv =====
// Register file of 256 64-bit registers with two registered read ports.
// Unwritten entries read as zero through per-entry valid bits.
// Depends on rme_pkg.
module rme_regfile
   import rme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [REG_ADDR_W-1:0] rd_addr_a,
   input  logic [REG_ADDR_W-1:0] rd_addr_b,
   input  wb_type                wb,
   output logic [WORD_W-1:0]     rd_data_a,
   output logic [WORD_W-1:0]     rd_data_b
);

   logic [WORD_W-1:0]    mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]    rd_a_ff;
   logic [WORD_W-1:0]    rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wb.en) begin
         valid_ff[wb.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wb.en) begin
         mem_ff[wb.addr] <= wb.data;
      end
   end

   // A read that coincides with a write to the same register returns the new value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wb.en && (wb.addr == rd_addr_a)) begin
            rd_a_ff <= wb.data;
         end else begin
            rd_a_ff <= valid_ff[rd_addr_a] ? mem_ff[rd_addr_a] : '0;
         end
         if (wb.en && (wb.addr == rd_addr_b)) begin
            rd_b_ff <= wb.data;
         end else begin
            rd_b_ff <= valid_ff[rd_addr_b] ? mem_ff[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== sv/rme_exec.sv =====
// Execute stage: instruction register, operand forwarding, halt and step control,
// the instruction pointer, the adder and the multiplier partial products.
// Depends on rme_pkg.
module rme_exec
   import rme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic [COUNT_W-1:0]    step_limit,
   input  fwd_type               fwd,
   input  logic                  res_ready,
   input  logic [WORD_W-1:0]     rd_data_a,
   input  logic [WORD_W-1:0]     rd_data_b,
   output logic                  rd_en,
   output logic [REG_ADDR_W-1:0] rd_addr_a,
   output logic [REG_ADDR_W-1:0] rd_addr_b,
   output logic                  go,
   output exec_res_type          res
);

   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_insn_ff;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [1:0]            halt_ff, halt_in;

   logic                  accept;
   logic                  hazard;
   logic [REG_ADDR_W-1:0] addr_a;
   logic [WORD_W-1:0]     opa, opb, opm;
   logic [1:0]            halt_cur;
   logic [INDEX_BITS-1:0] yz_idx, idx_next, idx_fwd, idx_back;
   logic                  op_zero, op_pos;
   logic [1:0]            status;
   logic [INDEX_BITS-1:0] next;
   logic                  wrote, is_mul;
   logic [WORD_W-1:0]     value;

   assign addr_a = is_branch(s1_insn_ff.opcode) ? s1_insn_ff.x_field : s1_insn_ff.y_field;

   assign hazard = fwd.busy && fwd.wrote
      && ((uses_port_a(s1_insn_ff.opcode) && (fwd.dest == addr_a))
      || (uses_port_b(s1_insn_ff.opcode) && (fwd.dest == s1_insn_ff.z_field)));

   assign go        = s1_valid_ff && !hazard && res_ready;
   assign req_ready = !s1_valid_ff || go;
   assign accept    = req_valid && req_ready;

   assign rd_en     = accept;
   assign rd_addr_a = is_branch(req_data.opcode) ? req_data.x_field : req_data.y_field;
   assign rd_addr_b = req_data.z_field;

   assign opa = (fwd.wrote && (fwd.dest == addr_a)) ? fwd.value : rd_data_a;
   assign opb = (fwd.wrote && (fwd.dest == s1_insn_ff.z_field)) ? fwd.value : rd_data_b;
   assign opm = uses_port_b(s1_insn_ff.opcode) ? opb : WORD_W'(s1_insn_ff.z_field);

   assign yz_idx   = INDEX_BITS'({s1_insn_ff.y_field, s1_insn_ff.z_field});
   assign idx_next = index_ff + INDEX_BITS'(1'b1);
   assign idx_fwd  = idx_next + yz_idx;
   assign idx_back = idx_next - yz_idx;
   assign op_zero  = (opa == '0);
   assign op_pos   = !op_zero && !opa[WORD_W-1];

   always_comb begin
      halt_cur = ((halt_ff == ST_RUN) && (count_ff == step_limit)) ? ST_LIMIT : halt_ff;
      status   = halt_cur;
      next     = index_ff;
      wrote    = 1'b0;
      is_mul   = 1'b0;
      value    = '0;
      if (halt_cur == ST_RUN) begin
         next = idx_next;
         unique case (s1_insn_ff.opcode)
            OP_TRAP: begin
               if ((s1_insn_ff.x_field == '0) && (s1_insn_ff.y_field == '0)
                  && (s1_insn_ff.z_field == '0)) begin
                  status = ST_TRAP;
                  next   = index_ff;
               end
            end
            OP_MULR, OP_MULI: begin
               wrote  = 1'b1;
               is_mul = 1'b1;
            end
            OP_ADDR, OP_ADDI: begin
               wrote = 1'b1;
               value = opa + opm;
            end
            OP_SUBR, OP_SUBI: begin
               wrote = 1'b1;
               value = opa - opm;
            end
            OP_BZF: begin
               if (op_zero) next = idx_fwd;
            end
            OP_BZB: begin
               if (op_zero) next = idx_back;
            end
            OP_BPF: begin
               if (op_pos) next = idx_fwd;
            end
            OP_BPB: begin
               if (op_pos) next = idx_back;
            end
            OP_SETL: begin
               wrote = 1'b1;
               value = WORD_W'({s1_insn_ff.y_field, s1_insn_ff.z_field});
            end
            default: begin
               status = ST_BADOP;
               next   = index_ff;
            end
         endcase
      end
   end

   always_comb begin
      res.next_index = NEXT_INDEX_W'(next);
      res.status     = status;
      res.wrote      = wrote;
      res.dest_reg   = wrote ? s1_insn_ff.x_field : '0;
      res.value      = value;
      res.is_mul     = is_mul;
      res.p_ll       = {{HALF_W{1'b0}}, opa[HALF_W-1:0]} * {{HALF_W{1'b0}}, opm[HALF_W-1:0]};
      res.p_lh       = opa[HALF_W-1:0] * opm[WORD_W-1:HALF_W];
      res.p_hl       = opa[WORD_W-1:HALF_W] * opm[HALF_W-1:0];
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (go ? 1'b0 : s1_valid_ff);
      index_in    = go ? next : index_ff;
      count_in    = (go && (halt_cur == ST_RUN)) ? count_ff + COUNT_W'(1'b1) : count_ff;
      halt_in     = go ? status : halt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         index_ff    <= '0;
         count_ff    <= '0;
         halt_ff     <= ST_RUN;
      end else begin
         s1_valid_ff <= s1_valid_in;
         index_ff    <= index_in;
         count_ff    <= count_in;
         halt_ff     <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_insn_ff <= req_data;
      end
   end

endmodule

// ===== sv/rme_result.sv =====
// Result stage: output register, final multiply sum, register write-back
// and the forwarding view of the last executed instruction.
// Depends on rme_pkg.
module rme_result
   import rme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  exec_res_type res,
   output logic         res_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   output wb_type       wb,
   output fwd_type      fwd
);

   exec_res_type      s2_ff;
   logic              s2_valid_ff, s2_valid_in;
   logic              wb_ff, wb_in;
   logic [WORD_W-1:0] final_value;
   logic [HALF_W-1:0] cross_sum;

   assign cross_sum   = s2_ff.p_lh + s2_ff.p_hl;
   assign final_value = s2_ff.is_mul ? s2_ff.p_ll + {cross_sum, {HALF_W{1'b0}}} : s2_ff.value;

   assign res_ready   = !s2_valid_ff || rsp_ready;
   assign s2_valid_in = go || (s2_valid_ff && !rsp_ready);
   assign wb_in       = go && res.wrote;

   // The register write lands in the cycle after the result is loaded; the multiply
   // sum is folded into the value register at the same edge unless a new result loads.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         wb_ff        <= 1'b0;
         s2_ff.wrote  <= 1'b0;
         s2_ff.is_mul <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         wb_ff       <= wb_in;
         if (go) begin
            s2_ff <= res;
         end else if (wb_ff) begin
            s2_ff.value  <= final_value;
            s2_ff.is_mul <= 1'b0;
         end
      end
   end

   assign rsp_valid           = s2_valid_ff;
   assign rsp_data.next_index = s2_ff.next_index;
   assign rsp_data.status     = s2_ff.status;
   assign rsp_data.wrote      = s2_ff.wrote;
   assign rsp_data.dest_reg   = s2_ff.dest_reg;
   assign rsp_data.dest_value = final_value;

   assign wb.en   = wb_ff;
   assign wb.addr = s2_ff.dest_reg;
   assign wb.data = final_value;

   assign fwd.wrote = s2_ff.wrote;
   assign fwd.busy  = s2_ff.is_mul;
   assign fwd.dest  = s2_ff.dest_reg;
   assign fwd.value = s2_ff.value;

endmodule
